FILE: rtl/core/bmhq_pkg.sv
// Shared types and codes for the binary max-heap priority queue.
package bmhq_pkg;

    localparam int PRIO_W  = 16;
    localparam int ID_W    = 16;
    localparam int COUNT_W = 7;

    // Command codes carried on the input channel.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes reported with every result.
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // One heap entry as it is held in the heap memory.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_entry;

    // Input transaction payload.
    typedef struct packed {
        logic              cmd;
        logic [PRIO_W-1:0] entry_priority;
        logic [ID_W-1:0]   entry_id;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic [1:0]         status;
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic [PRIO_W-1:0]  head_priority;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

endpackage

FILE: rtl/core/bmhq_ram.sv
// Generic single-write, single-read memory with a registered read port.
module bmhq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/binary_max_heap_queue_core.sv
// Binary max-heap priority queue kept in one heap memory with a sift sequencer.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one transaction per
// command: an insert carrying a priority and an id, or a remove of the top entry.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
// transaction per command: the status, the head entry and the entry count after
// the command. A full queue rejects an insert and an empty queue rejects a remove;
// the state is then left as it was.
// Entries live in one memory of CAPACITY words with a registered read.
// The moving entry is held in a register and the hole walks through the tree,
// so every level costs memory reads plus one write:
//   insert : a parent read and a write per level climbed
//   remove : last entry loaded, then two child reads and a write per level
//   rejected command or removal of the last entry : straight to the result step
// One command is worked at a time; o_in_ready is high only while the sequencer is
// idle, which it is again as soon as each result is loaded. The result sits in
// an output register, so a new command is accepted while the previous result waits;
// a command finishing while the receiver stalls holds until the register frees up.
// Reset empties the queue at once; memory contents need no clearing.
module binary_max_heap_queue_core #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bmhq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bmhq_pkg::t_out_item o_out_data
);

    import bmhq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = IW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SU_RD,
        S_SU_CMP,
        S_RM_RD,
        S_RM_LD,
        S_SD_L,
        S_SD_R,
        S_SD_C,
        S_FIN
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_fill;
    logic [IW-1:0]   r_pos;
    t_entry          r_x;
    t_entry          r_left;
    logic            r_has_right;
    t_entry          r_head;
    logic [1:0]      r_status;
    logic            r_out_valid;
    t_out_item       r_out;

    logic            w_we;
    logic [IW-1:0]   w_waddr;
    t_entry          w_wdata;
    logic [IW-1:0]   w_raddr;
    t_entry          w_rdata;

    logic [KW-1:0]   w_kid;
    logic [KW-1:0]   w_kid1;
    logic [KW-1:0]   w_n;
    logic            w_kid_in;
    logic            w_kid1_in;
    logic [IW-1:0]   w_parent;
    logic            w_up_go;
    logic            w_pick_right;
    t_entry          w_child;
    logic [IW-1:0]   w_child_idx;
    logic            w_down_go;
    logic            w_accept;
    logic            w_out_free;
    logic            w_nonempty;
    logic [CW+COUNT_W-1:0] w_count_ext;
    t_out_item       n_out;

    // Heap storage.
    bmhq_ram #(
        .DATA_W ($bits(t_entry)),
        .DEPTH  (CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Tree index arithmetic: children of the hole and its parent.
    assign w_kid     = {r_pos, 1'b1};
    assign w_kid1    = w_kid + 1'b1;
    assign w_n       = KW'(r_fill);
    assign w_kid_in  = (w_kid < w_n);
    assign w_kid1_in = (w_kid1 < w_n);
    assign w_parent  = (r_pos - 1'b1) >> 1;

    // Sift decisions. A tie lets the climbing entry pass its parent; the right
    // child wins only when strictly greater than the left one.
    assign w_up_go      = (w_rdata.prio <= r_x.prio);
    assign w_pick_right = r_has_right && (r_left.prio < w_rdata.prio);
    assign w_child      = w_pick_right ? w_rdata : r_left;
    assign w_child_idx  = w_pick_right ? w_kid1[IW-1:0] : w_kid[IW-1:0];
    assign w_down_go    = (r_x.prio < w_child.prio);

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Memory port control for each sequencer step.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_x;
        w_raddr = r_fill[IW-1:0];
        case (r_state)
            S_SU_RD: begin
                w_raddr = w_parent;
                if (r_pos == '0) begin
                    w_we = 1'b1;
                end
            end
            S_SU_CMP: begin
                w_we = 1'b1;
                if (w_up_go) begin
                    w_wdata = w_rdata;
                end
            end
            S_SD_L: begin
                w_raddr = w_kid[IW-1:0];
                if (!w_kid_in) begin
                    w_we = 1'b1;
                end
            end
            S_SD_R: begin
                w_raddr = w_kid1[IW-1:0];
            end
            S_SD_C: begin
                w_we = 1'b1;
                if (w_down_go) begin
                    w_wdata = w_child;
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Result built from the state left by the command.
    assign w_nonempty  = (r_fill != '0);
    assign w_count_ext = {{COUNT_W{1'b0}}, r_fill};
    always_comb begin
        n_out               = '0;
        n_out.status        = r_status;
        n_out.head_valid    = w_nonempty;
        n_out.head_id       = w_nonempty ? r_head.id : '0;
        n_out.head_priority = w_nonempty ? r_head.prio : '0;
        n_out.entry_count   = w_count_ext[COUNT_W-1:0];
    end

    // Sequencer, queue bookkeeping and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_has_right <= 1'b0;
            r_status    <= STATUS_DONE;
        end else begin
            // The root copy follows every write to the top slot.
            if (w_we && (w_waddr == '0)) begin
                r_head <= w_wdata;
            end

            // The final step reloads the output register itself.
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_data.cmd == CMD_INSERT) begin
                            if (r_fill == CW'(CAPACITY)) begin
                                r_status <= STATUS_FULL;
                                r_state  <= S_FIN;
                            end else begin
                                r_status  <= STATUS_DONE;
                                r_pos     <= r_fill[IW-1:0];
                                r_x.prio  <= i_in_data.entry_priority;
                                r_x.id    <= i_in_data.entry_id;
                                r_fill    <= r_fill + 1'b1;
                                r_state   <= S_SU_RD;
                            end
                        end else begin
                            if (r_fill == '0) begin
                                r_status <= STATUS_EMPTY;
                                r_state  <= S_FIN;
                            end else begin
                                r_status <= STATUS_DONE;
                                r_fill   <= r_fill - 1'b1;
                                if (r_fill == CW'(1)) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_RM_RD;
                                end
                            end
                        end
                    end
                end
                S_SU_RD: begin
                    if (r_pos == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SU_CMP;
                    end
                end
                S_SU_CMP: begin
                    if (w_up_go) begin
                        r_pos   <= w_parent;
                        r_state <= S_SU_RD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RM_RD: begin
                    r_state <= S_RM_LD;
                end
                S_RM_LD: begin
                    r_x     <= w_rdata;
                    r_pos   <= '0;
                    r_state <= S_SD_L;
                end
                S_SD_L: begin
                    if (w_kid_in) begin
                        r_state <= S_SD_R;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SD_R: begin
                    r_left      <= w_rdata;
                    r_has_right <= w_kid1_in;
                    r_state     <= S_SD_C;
                end
                S_SD_C: begin
                    if (w_down_go) begin
                        r_pos   <= w_child_idx;
                        r_state <= S_SD_L;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out       <= n_out;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
